/* design/sadpcm_pkg.sv */
// shared types, constants and coefficient tables for the spu adpcm block decoder
`timescale 1ns / 1ps
`default_nettype none

package sadpcm_pkg;

  // offset register width default and fixed field widths
  localparam int SADPCM_OFFSET_WIDTH = 20;
  localparam int OFFSET_FIELD_W      = 20;
  localparam int STREAM_W            = 20;
  localparam int SAMPLE_W            = 16;
  localparam int DATA_W              = 56;
  localparam int BLOCK_DATA_W        = 2 * DATA_W;

  // block geometry
  localparam int BLOCK_BYTES   = 16;
  localparam int BLOCK_SAMPLES = 28;
  localparam int CNT_W         = $clog2(BLOCK_SAMPLES);

  // header decoding limits
  localparam int SHIFT_MAX  = 12;
  localparam int FILTER_MAX = 4;

  // prediction scaling: divide by 64, truncating toward zero
  localparam int PRED_DIV   = 64;
  localparam int PRED_SHIFT = $clog2(PRED_DIV);

  // saturation limits
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // input mode codes
  localparam logic MODE_START  = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // flag bit positions in flags_byte
  localparam int FLAG_END    = 0;
  localparam int FLAG_REPEAT = 1;
  localparam int FLAG_LOOP   = 2;

  // kind of work handed to the back end
  typedef enum logic [1:0] {
    CMD_START,
    CMD_STATUS,
    CMD_DECODE
  } cmd_kind_t;

  // voice status reported with every result of one transaction
  typedef struct packed {
    logic [OFFSET_FIELD_W-1:0] next_offset;
    logic                      done;
    logic                      looped;
  } status_t;

  // one queued command
  typedef struct packed {
    cmd_kind_t               kind;
    logic [3:0]              shift;
    logic [2:0]              filter;
    logic [BLOCK_DATA_W-1:0] data;
    status_t                 status;
  } cmd_t;

  // first prediction tap
  function automatic logic signed [7:0] coef_a(input logic [2:0] filter);
    logic signed [7:0] c;
    unique case (filter)
      3'd1:    c = 8'sd60;
      3'd2:    c = 8'sd115;
      3'd3:    c = 8'sd98;
      3'd4:    c = 8'sd122;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  // second prediction tap
  function automatic logic signed [7:0] coef_b(input logic [2:0] filter);
    logic signed [7:0] c;
    unique case (filter)
      3'd2:    c = -8'sd52;
      3'd3:    c = -8'sd55;
      3'd4:    c = -8'sd60;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* design/sadpcm_ifs.sv */
// valid/ready channel interfaces for block input and sample output
`timescale 1ns / 1ps
`default_nettype none

interface sadpcm_in_if import sadpcm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [7:0]        header_byte;
  logic [7:0]        flags_byte;
  logic [DATA_W-1:0] data_low;
  logic [DATA_W-1:0] data_high;

  modport source (output valid, mode, header_byte, flags_byte, data_low, data_high,
                  input ready);
  modport sink   (input valid, mode, header_byte, flags_byte, data_low, data_high,
                  output ready);
endinterface

interface sadpcm_out_if import sadpcm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       sample_valid;
  logic                       last;
  logic [OFFSET_FIELD_W-1:0]  next_offset;
  logic                       voice_done;
  logic                       has_looped;

  modport source (output valid, sample, sample_valid, last, next_offset, voice_done,
                  has_looped, input ready);
  modport sink   (input valid, sample, sample_valid, last, next_offset, voice_done,
                  has_looped, output ready);
endinterface

`default_nettype wire

/* design/sadpcm_front.sv */
// front end: accepts blocks, tracks offsets and end state, issues commands
`timescale 1ns / 1ps
`default_nettype none

module sadpcm_front import sadpcm_pkg::*; #(
  parameter int OFFSET_WIDTH = SADPCM_OFFSET_WIDTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [STREAM_W-1:0] cfg_wdata,
  sadpcm_in_if.sink                in_ch,
  input  wire logic                q_full,
  output logic                     q_push,
  output cmd_t                     q_cmd
);

  localparam int EXT_W = 33;

  logic [STREAM_W-1:0]     stream_bytes;
  logic [OFFSET_WIDTH-1:0] block_offset, block_offset_next;
  logic [OFFSET_WIDTH-1:0] loop_offset, loop_offset_next;
  logic                    finished, finished_next;
  logic                    looped_flag, looped_flag_next;

  logic [EXT_W-1:0]        end_ext;
  logic                    past_end;
  logic [EXT_W-1:0]        status_off_ext;
  logic [3:0]              hdr_shift;
  logic [3:0]              hdr_filter;
  cmd_kind_t               kind;

  // accept whenever the queue has room
  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // end-of-stream check on the current block
  assign end_ext  = EXT_W'(block_offset) + EXT_W'(BLOCK_BYTES);
  assign past_end = end_ext > EXT_W'(stream_bytes);

  assign hdr_shift  = in_ch.header_byte[3:0];
  assign hdr_filter = in_ch.header_byte[7:4];

  // classify the transaction and work out the next voice state
  always_comb begin
    block_offset_next = block_offset;
    loop_offset_next  = loop_offset;
    finished_next     = finished;
    looped_flag_next  = looped_flag;
    kind              = CMD_STATUS;
    priority if (in_ch.mode == MODE_START) begin
      kind              = CMD_START;
      block_offset_next = '0;
      loop_offset_next  = '0;
      looped_flag_next  = 1'b0;
      finished_next     = stream_bytes < STREAM_W'(BLOCK_BYTES);
    end else if (finished) begin
      kind = CMD_STATUS;
    end else if (past_end) begin
      kind          = CMD_STATUS;
      finished_next = 1'b1;
    end else begin
      kind              = CMD_DECODE;
      block_offset_next = block_offset + OFFSET_WIDTH'(BLOCK_BYTES);
      if (in_ch.flags_byte[FLAG_LOOP]) begin
        loop_offset_next = block_offset;
      end
      if (in_ch.flags_byte[FLAG_END]) begin
        if (in_ch.flags_byte[FLAG_REPEAT]) begin
          block_offset_next = loop_offset_next;
          looped_flag_next  = 1'b1;
        end else begin
          finished_next = 1'b1;
        end
      end
    end
  end

  // build the command for the back end
  assign status_off_ext = EXT_W'(block_offset_next);

  always_comb begin
    q_cmd.kind               = kind;
    q_cmd.shift              = (hdr_shift > 4'(SHIFT_MAX)) ? 4'(SHIFT_MAX) : hdr_shift;
    q_cmd.filter             = (hdr_filter > 4'(FILTER_MAX)) ? 3'd0 : hdr_filter[2:0];
    q_cmd.data               = {in_ch.data_high, in_ch.data_low};
    q_cmd.status.next_offset = status_off_ext[OFFSET_FIELD_W-1:0];
    q_cmd.status.done        = finished_next;
    q_cmd.status.looped      = looped_flag_next;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      stream_bytes <= '0;
    end else if (cfg_we) begin
      stream_bytes <= cfg_wdata;
    end
  end

  // voice state
  always_ff @(posedge clk) begin
    if (rst) begin
      block_offset <= '0;
      loop_offset  <= '0;
      finished     <= 1'b1;
      looped_flag  <= 1'b0;
    end else if (q_push) begin
      block_offset <= block_offset_next;
      loop_offset  <= loop_offset_next;
      finished     <= finished_next;
      looped_flag  <= looped_flag_next;
    end
  end

endmodule

`default_nettype wire

/* design/sadpcm_queue.sv */
// short command queue between front and back end
`timescale 1ns / 1ps
`default_nettype none

module sadpcm_queue import sadpcm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_cmd,
  output logic      empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_Q = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_Q-1:0] count;

  assign full    = count == CNT_Q'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign pop_cmd = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // no overflow, no underflow, count in range
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_Q'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

/* design/sadpcm_back.sv */
// back end: sample loop with two-tap prediction and the output register
`timescale 1ns / 1ps
`default_nettype none

module sadpcm_back import sadpcm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  cmd_t      q_cmd,
  input  wire logic q_empty,
  output logic      q_pop,
  sadpcm_out_if.source out_ch
);

  localparam logic signed [19:0] SUM_MAX  = 20'(SAMPLE_MAX);
  localparam logic signed [19:0] SUM_MIN  = 20'(SAMPLE_MIN);
  localparam logic signed [24:0] DIV_BIAS = 25'(PRED_DIV - 1);

  cmd_t                       cur;
  logic                       busy;
  logic [CNT_W-1:0]           cnt;
  logic signed [SAMPLE_W-1:0] hist1, hist2;

  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_sample_valid;
  logic                       out_last;
  status_t                    out_status;

  logic                       load_ok;
  logic                       advance;
  logic                       single;
  logic                       last_res;
  logic                       finishing;

  logic [3:0]                 nib;
  logic signed [15:0]         resid_base;
  logic signed [15:0]         resid;
  logic signed [7:0]          ca, cb;
  logic signed [23:0]         pa, pb;
  logic signed [24:0]         psum;
  logic signed [24:0]         padj;
  logic signed [18:0]         pred;
  logic signed [19:0]         total;
  logic signed [SAMPLE_W-1:0] sat;

  // loop control
  assign load_ok   = !out_valid || out_ch.ready;
  assign advance   = busy && load_ok;
  assign single    = cur.kind != CMD_DECODE;
  assign last_res  = single || (cnt == CNT_W'(BLOCK_SAMPLES - 1));
  assign finishing = advance && last_res;
  assign q_pop     = !q_empty && (!busy || finishing);

  // residual: nibble in the top of the word, arithmetic shift
  assign nib        = cur.data[{cnt, 2'b00} +: 4];
  assign resid_base = {nib, 12'h000};
  assign resid      = resid_base >>> cur.shift;

  // prediction from the last two samples, divided toward zero
  assign ca   = coef_a(cur.filter);
  assign cb   = coef_b(cur.filter);
  assign pa   = ca * hist1;
  assign pb   = cb * hist2;
  assign psum = 25'(pa) + 25'(pb);
  assign padj = (psum < 0) ? psum + DIV_BIAS : psum;
  assign pred = 19'(padj >>> PRED_SHIFT);

  // sum and saturate
  assign total = 20'(resid) + 20'(pred);

  always_comb begin
    priority if (total > SUM_MAX) begin
      sat = SAMPLE_W'(SAMPLE_MAX);
    end else if (total < SUM_MIN) begin
      sat = SAMPLE_W'(SAMPLE_MIN);
    end else begin
      sat = total[SAMPLE_W-1:0];
    end
  end

  // current command
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end
  end

  // busy flag and sample counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (q_pop) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (finishing) begin
      busy <= 1'b0;
    end else if (advance) begin
      cnt <= cnt + 1'b1;
    end
  end

  // prediction history
  always_ff @(posedge clk) begin
    if (rst) begin
      hist1 <= '0;
      hist2 <= '0;
    end else if (advance) begin
      if (cur.kind == CMD_START) begin
        hist1 <= '0;
        hist2 <= '0;
      end else if (cur.kind == CMD_DECODE) begin
        hist2 <= hist1;
        hist1 <= sat;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ok) begin
      out_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_sample       <= single ? '0 : sat;
      out_sample_valid <= !single;
      out_last         <= last_res;
      out_status       <= cur.status;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.sample       = out_sample;
  assign out_ch.sample_valid = out_sample_valid;
  assign out_ch.last         = out_last;
  assign out_ch.next_offset  = out_status.next_offset;
  assign out_ch.voice_done   = out_status.done;
  assign out_ch.has_looped   = out_status.looped;

  // counter stays inside the block
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt <= CNT_W'(BLOCK_SAMPLES - 1))
    else $error("sample counter past end of block");
  // a status-only transaction is always its own last result
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_sample_valid) |-> out_last)
    else $error("status result without last");
  // a start clears the history
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && cur.kind == CMD_START) |=> (hist1 == '0 && hist2 == '0))
    else $error("history not cleared by start");

endmodule

`default_nettype wire

/* design/spu_adpcm_block_decoder.sv */
// top level of the spu adpcm block decoder
`timescale 1ns / 1ps
`default_nettype none

// Decodes one 16-byte SPU-ADPCM block per input transaction into 28 saturated
// 16-bit samples, one result transaction per sample, with the voice status
// (next block offset, done, looped) on every result and last on the final one.
// A start transaction, a decode while the voice is done, or a block past the
// configured stream size gives a single status result instead. The back end
// produces one result per cycle unless the output channel stalls it, from a
// sample loop in which each sample's prediction uses the two samples before
// it. The front end keeps taking transactions into a two-entry command queue
// while the back end works, so blocks run back to back with no gap. Write
// stream_bytes only while the decoder is idle.

module spu_adpcm_block_decoder import sadpcm_pkg::*; #(
  parameter int OFFSET_WIDTH = SADPCM_OFFSET_WIDTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [STREAM_W-1:0] cfg_wdata,
  sadpcm_in_if.sink                in_ch,
  sadpcm_out_if.source             out_ch
);

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  // front end
  sadpcm_front #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  // command queue
  sadpcm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  // back end
  sadpcm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_cmd   (pop_cmd),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

/* tb/tb.sv */
// self-checking testbench for the spu adpcm block decoder
`timescale 1ns / 1ps

module tb;
  import sadpcm_pkg::*;

  // one block transaction as offered on the input channel
  typedef struct {
    logic              mode;
    logic [7:0]        header_byte;
    logic [7:0]        flags_byte;
    logic [DATA_W-1:0] data_low;
    logic [DATA_W-1:0] data_high;
  } block_item_t;

  // one expected result transaction
  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sample_valid;
    logic                       last;
    logic [OFFSET_FIELD_W-1:0]  next_offset;
    logic                       voice_done;
    logic                       has_looped;
  } pcm_result_t;

  // flag masks built from the package bit positions
  localparam logic [7:0] F_END    = 8'd1 << FLAG_END;
  localparam logic [7:0] F_REPEAT = 8'd1 << FLAG_REPEAT;
  localparam logic [7:0] F_LOOP   = 8'd1 << FLAG_LOOP;
  localparam logic [7:0] F_UNUSED = 8'hF8;

  // nibble patterns for the data fields
  localparam logic [DATA_W-1:0] NIB_ZERO   = '0;
  localparam logic [DATA_W-1:0] NIB_ONES   = '1;
  localparam logic [DATA_W-1:0] NIB_SEVENS = {14{4'h7}};
  localparam logic [DATA_W-1:0] NIB_EIGHTS = {14{4'h8}};

  localparam int STREAM_MAX  = 524288;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 40;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [STREAM_W-1:0] cfg_wdata = '0;

  sadpcm_in_if  in_ch ();
  sadpcm_out_if out_ch ();

  spu_adpcm_block_decoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // clock
  always #5 clk = ~clk;

  // stimulus and expectation stores
  block_item_t block_pending_q[$];
  pcm_result_t pcm_expect_q[$];

  // decoder state shadow
  logic [STREAM_W-1:0]       stream_len = '0;
  logic [OFFSET_FIELD_W-1:0] vox_offset = '0;
  logic [OFFSET_FIELD_W-1:0] vox_loop = '0;
  int                        hist1 = 0;
  int                        hist2 = 0;
  logic                      vox_finished = 1'b1;
  logic                      vox_looped = 1'b0;

  // handshake control
  logic in_taken = 1'b0;
  logic recv_hold = 1'b0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic gen_ended = 1'b0;

  // bookkeeping
  int n_queued = 0;
  int n_accepted = 0;
  int n_starts = 0;
  int n_results = 0;
  int n_samples = 0;
  int n_status = 0;
  int n_settings = 0;
  int n_errors = 0;

  // one line per mismatch
  task automatic note_mismatch(input string field, input longint got, input longint want);
    n_errors++;
    $display("%0t: mismatch on %s at result %0d: got %0d, expected %0d",
             $time, field, n_results, got, want);
  endtask

  // queue one result carrying the current voice status
  function automatic void push_status(input logic signed [SAMPLE_W-1:0] smp,
                                      input logic vld, input logic lst);
    pcm_result_t r;
    r.sample       = smp;
    r.sample_valid = vld;
    r.last         = lst;
    r.next_offset  = vox_offset;
    r.voice_done   = vox_finished;
    r.has_looped   = vox_looped;
    pcm_expect_q.push_back(r);
  endfunction

  // work out the results of one accepted block transaction
  function automatic void predict_block(input block_item_t it);
    logic [2*DATA_W-1:0]       nibbles;
    logic [OFFSET_FIELD_W-1:0] here;
    int                        shift;
    int                        filt;
    int                        tap1;
    int                        tap2;
    int                        resid;
    int                        acc;
    int                        pcm[BLOCK_SAMPLES];
    if (it.mode == MODE_START) begin
      vox_offset   = '0;
      vox_loop     = '0;
      hist1        = 0;
      hist2        = 0;
      vox_looped   = 1'b0;
      vox_finished = (stream_len < BLOCK_BYTES);
      push_status('0, 1'b0, 1'b1);
    end else if (vox_finished) begin
      push_status('0, 1'b0, 1'b1);
    end else if (int'(vox_offset) + BLOCK_BYTES > int'(stream_len)) begin
      // block runs past the stream: voice stops, no samples
      vox_finished = 1'b1;
      push_status('0, 1'b0, 1'b1);
    end else begin
      shift = int'(it.header_byte[3:0]);
      filt  = int'(it.header_byte[7:4]);
      if (filt > FILTER_MAX) filt = 0;
      if (shift > SHIFT_MAX) shift = SHIFT_MAX;
      case (filt)
        1: begin tap1 = 60;  tap2 = 0;   end
        2: begin tap1 = 115; tap2 = -52; end
        3: begin tap1 = 98;  tap2 = -55; end
        4: begin tap1 = 122; tap2 = -60; end
        default: begin tap1 = 0; tap2 = 0; end
      endcase
      nibbles = {it.data_high, it.data_low};
      // serial sample loop, low nibble of each byte first
      for (int i = 0; i < BLOCK_SAMPLES; i++) begin
        resid = int'($signed(nibbles[4*i +: 4]));
        acc   = (resid * 4096) >>> shift;
        acc   = acc + (tap1 * hist1 + tap2 * hist2) / 64;
        if (acc > SAMPLE_MAX) acc = SAMPLE_MAX;
        if (acc < SAMPLE_MIN) acc = SAMPLE_MIN;
        pcm[i] = acc;
        hist2  = hist1;
        hist1  = acc;
      end
      // offset tracking and flag handling
      here       = vox_offset;
      vox_offset = here + OFFSET_FIELD_W'(BLOCK_BYTES);
      if (it.flags_byte[FLAG_LOOP]) vox_loop = here;
      if (it.flags_byte[FLAG_END]) begin
        if (it.flags_byte[FLAG_REPEAT]) begin
          vox_offset = vox_loop;
          vox_looped = 1'b1;
        end else begin
          vox_finished = 1'b1;
        end
      end
      for (int i = 0; i < BLOCK_SAMPLES; i++)
        push_status(SAMPLE_W'(pcm[i]), 1'b1, i == BLOCK_SAMPLES - 1);
    end
  endfunction

  // input driver: at each falling edge with no transaction waiting, offer the next one or idle
  always @(negedge clk) begin : block_driver
    block_item_t nxt;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (block_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = block_pending_q.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.mode        <= nxt.mode;
        in_ch.header_byte <= nxt.header_byte;
        in_ch.flags_byte  <= nxt.flags_byte;
        in_ch.data_low    <= nxt.data_low;
        in_ch.data_high   <= nxt.data_high;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    out_ch.ready <= !rst && !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin : pcm_monitor
    block_item_t taken;
    pcm_result_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        taken.mode        = in_ch.mode;
        taken.header_byte = in_ch.header_byte;
        taken.flags_byte  = in_ch.flags_byte;
        taken.data_low    = in_ch.data_low;
        taken.data_high   = in_ch.data_high;
        predict_block(taken);
        n_accepted++;
        if (taken.mode == MODE_START) n_starts++;
      end
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (pcm_expect_q.size() == 0) begin
          note_mismatch("unexpected result", out_ch.sample, 0);
        end else begin
          want = pcm_expect_q.pop_front();
          if (out_ch.sample !== want.sample)
            note_mismatch("sample", out_ch.sample, want.sample);
          if (out_ch.sample_valid !== want.sample_valid)
            note_mismatch("sample_valid", out_ch.sample_valid, want.sample_valid);
          if (out_ch.last !== want.last)
            note_mismatch("last", out_ch.last, want.last);
          if (out_ch.next_offset !== want.next_offset)
            note_mismatch("next_offset", out_ch.next_offset, want.next_offset);
          if (out_ch.voice_done !== want.voice_done)
            note_mismatch("voice_done", out_ch.voice_done, want.voice_done);
          if (out_ch.has_looped !== want.has_looped)
            note_mismatch("has_looped", out_ch.has_looped, want.has_looped);
          if (want.sample_valid) n_samples++;
          else n_status++;
        end
      end
    end
  end

  // register write, only while the decoder is idle
  task automatic set_stream_len(input int len);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= STREAM_W'(len);
    @(negedge clk);
    cfg_we     <= 1'b0;
    stream_len  = STREAM_W'(len);
    n_settings++;
    @(posedge clk);
  endtask

  task automatic push_block(input logic mode, input logic [7:0] header,
                            input logic [7:0] flags, input logic [DATA_W-1:0] lo,
                            input logic [DATA_W-1:0] hi);
    block_item_t it;
    it.mode        = mode;
    it.header_byte = header;
    it.flags_byte  = flags;
    it.data_low    = lo;
    it.data_high   = hi;
    block_pending_q.push_back(it);
    n_queued++;
  endtask

  // wait until every transaction is in and every result is out
  task automatic wait_drained();
    while (n_accepted != n_queued || pcm_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_nibbles();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      0: return NIB_ZERO;
      1: return NIB_ONES;
      2: return NIB_SEVENS;
      3: return NIB_EIGHTS;
      default: return r[DATA_W-1:0];
    endcase
  endfunction

  // mostly well-formed voices: a start, then decodes with random content
  task automatic queue_random_items(input int count);
    logic       mode;
    logic [7:0] ctrl;
    int         pick;
    for (int k = 0; k < count; k++) begin
      if (k == 0 || (gen_ended && $urandom_range(9) < 8) || $urandom_range(11) == 0)
        mode = MODE_START;
      else
        mode = MODE_DECODE;
      pick = $urandom_range(99);
      if (pick < 60)      ctrl = 8'h00;
      else if (pick < 72) ctrl = F_LOOP;
      else if (pick < 82) ctrl = F_END | F_REPEAT;
      else if (pick < 88) ctrl = F_END;
      else if (pick < 94) ctrl = F_LOOP | F_END | F_REPEAT;
      else                ctrl = F_REPEAT;
      gen_ended = (mode == MODE_DECODE) && (ctrl == F_END);
      push_block(mode, 8'($urandom_range(255)),
                 (8'($urandom_range(255)) & F_UNUSED) | ctrl,
                 pick_nibbles(), pick_nibbles());
    end
  endtask

  // main sequence
  initial begin : stimulus
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_START;
    in_ch.header_byte = '0;
    in_ch.flags_byte  = '0;
    in_ch.data_low    = '0;
    in_ch.data_high   = '0;
    out_ch.ready      = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every filter, shift clamping, saturation, loop and end flags
    set_stream_len(96);
    push_block(MODE_START,  8'h00, 8'h00, NIB_ZERO, NIB_ZERO);
    push_block(MODE_DECODE, 8'h0C, F_LOOP, NIB_ONES, NIB_ZERO);
    push_block(MODE_DECODE, 8'h10, 8'h00, NIB_SEVENS, NIB_SEVENS);
    push_block(MODE_DECODE, 8'h20, F_UNUSED, NIB_EIGHTS, NIB_EIGHTS);
    push_block(MODE_DECODE, 8'h3D, 8'h00, pick_nibbles(), NIB_ONES);
    push_block(MODE_DECODE, 8'h4F, 8'h00, NIB_SEVENS, pick_nibbles());
    push_block(MODE_DECODE, 8'h57, F_END | F_REPEAT, pick_nibbles(), pick_nibbles());
    push_block(MODE_DECODE, 8'hF0, F_LOOP | F_REPEAT, NIB_EIGHTS, NIB_SEVENS);
    push_block(MODE_DECODE, 8'h34, F_END, pick_nibbles(), pick_nibbles());
    push_block(MODE_DECODE, 8'h21, 8'h00, NIB_ONES, NIB_ONES);
    wait_drained();

    // running off the end of a short stream
    set_stream_len(32);
    push_block(MODE_START,  8'h00, 8'h00, NIB_ZERO, NIB_ZERO);
    push_block(MODE_DECODE, 8'h45, 8'h00, pick_nibbles(), pick_nibbles());
    push_block(MODE_DECODE, 8'h23, 8'h00, pick_nibbles(), pick_nibbles());
    push_block(MODE_DECODE, 8'h12, 8'h00, pick_nibbles(), pick_nibbles());
    push_block(MODE_DECODE, 8'h12, 8'h00, pick_nibbles(), pick_nibbles());
    wait_drained();

    // stream of exactly one block, just under one block, and empty
    set_stream_len(16);
    push_block(MODE_START,  8'h00, 8'h00, NIB_ZERO, NIB_ZERO);
    push_block(MODE_DECODE, 8'h48, 8'h00, pick_nibbles(), pick_nibbles());
    push_block(MODE_DECODE, 8'h48, 8'h00, pick_nibbles(), pick_nibbles());
    wait_drained();
    set_stream_len(15);
    push_block(MODE_START,  8'h00, 8'h00, NIB_ZERO, NIB_ZERO);
    push_block(MODE_DECODE, 8'h11, 8'h00, pick_nibbles(), pick_nibbles());
    wait_drained();
    set_stream_len(0);
    push_block(MODE_START,  8'h00, 8'h00, NIB_ZERO, NIB_ZERO);
    push_block(MODE_DECODE, 8'h11, 8'h00, pick_nibbles(), pick_nibbles());
    wait_drained();

    // random voices, no idling, with a long output stall up front
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_stream_len(STREAM_MAX);
    fork
      begin
        @(posedge clk);
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_hold <= 1'b0;
      end
    join_none
    queue_random_items(25);
    wait_drained();

    // sender idling
    send_idle_pct  = 48;
    recv_stall_pct = 0;
    set_stream_len(16 * $urandom_range(1, 10));
    queue_random_items(25);
    wait_drained();

    // receiver stalling, with a full pause of the sender half way
    send_idle_pct  = 0;
    recv_stall_pct = 48;
    set_stream_len($urandom_range(0, 200));
    queue_random_items(12);
    wait_drained();
    queue_random_items(13);
    wait_drained();

    // both sides idling
    send_idle_pct  = 34;
    recv_stall_pct = 34;
    set_stream_len(16 * $urandom_range(2, 6) + $urandom_range(0, 15));
    queue_random_items(25);
    wait_drained();

    // let any stray result show up
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("run covered %0d block transactions (%0d starts) over %0d stream lengths",
             n_accepted, n_starts, n_settings);
    $display("checked %0d samples and %0d status-only results under four idling mixes",
             n_samples, n_status);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(2_000_000);
    $display("timeout waiting for results");
    $display("Some tests failed");
    $finish;
  end

endmodule
